[hw/rtl/esc_pkg.sv]
// Shared types, constants and calendar helper functions for the epoch-to-calendar block.
`timescale 1ns / 1ps

package esc_pkg;

  localparam logic [31:0] DaySec    = 32'd86400;
  localparam logic [16:0] HourSec   = 17'd3600;
  localparam logic [11:0] MinSec    = 12'd60;
  localparam logic [17:0] HourSecS  = 18'd3600;
  localparam logic [7:0]  EpochYear = 8'd70;
  localparam logic [3:0]  MonthDec  = 4'd11;
  localparam logic [3:0]  MonthFeb  = 4'd1;
  localparam logic [3:0]  DayBits   = 4'd15;
  localparam logic [3:0]  HourBits  = 4'd4;
  localparam logic [3:0]  MinBits   = 4'd5;
  localparam logic [2:0]  EpochWday = 3'd4;

  typedef struct packed {
    logic       load;
    logic       day_step;
    logic       hour_step;
    logic       min_step;
    logic       year_step;
    logic       month_step;
    logic       publish;
    logic [3:0] step;
  } esc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } esc_sts_t;

  // year given as offset from 1900
  function automatic logic is_leap(input logic [7:0] yr);
    is_leap = (yr[1:0] == 2'b00) && (yr != 8'd0) && (yr != 8'd200);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    month_len = len;
  endfunction

endpackage

[hw/rtl/esc_dp.sv]
// Datapath: offset add with saturation, shift-subtract dividers, year and month walk.
`timescale 1ns / 1ps

module esc_dp import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic [31:0] unix_seconds_i,
  input  esc_cmd_t    cmd_i,
  output esc_sts_t    sts_o,
  output logic [7:0]  years_since_1900_o,
  output logic [3:0]  month_index_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o,
  output logic [2:0]  day_of_week_o
);

  logic [4:0]  offset_q;
  logic [31:0] t_q;
  logic [15:0] days_q;
  logic [2:0]  wd_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [7:0]  year_q;
  logic [3:0]  month_q;

  logic [7:0]  out_year_q;
  logic [3:0]  out_month_q;
  logic [4:0]  out_day_q;
  logic [4:0]  out_hour_q;
  logic [5:0]  out_min_q;
  logic [5:0]  out_sec_q;
  logic [2:0]  out_wday_q;

  logic signed [17:0] off_ext;
  logic signed [17:0] off_sec;
  logic signed [33:0] sum;
  logic [31:0] t_init;
  logic [31:0] day_div;
  logic        day_ge;
  logic [3:0]  wd_dbl;
  logic [2:0]  wd_next;
  logic [16:0] hour_div;
  logic        hour_ge;
  logic [11:0] min_div;
  logic        min_ge;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [3:0]  wd_sum;
  logic [2:0]  wd_final;

  always_comb begin
    off_ext = {{13{offset_q[4]}}, offset_q};
    off_sec = off_ext * $signed(HourSecS);
    sum     = $signed({2'b00, unix_seconds_i}) + $signed({{16{off_sec[17]}}, off_sec});
    if (sum[33]) begin
      t_init = '0;
    end else if (sum[32]) begin
      t_init = '1;
    end else begin
      t_init = sum[31:0];
    end

    day_div  = DaySec << cmd_i.step;
    day_ge   = (t_q >= day_div);
    wd_dbl   = {wd_q, day_ge};
    wd_next  = (wd_dbl >= 4'd7) ? 3'(wd_dbl - 4'd7) : wd_dbl[2:0];

    hour_div = HourSec << cmd_i.step;
    hour_ge  = (t_q[16:0] >= hour_div);
    min_div  = MinSec << cmd_i.step;
    min_ge   = (t_q[11:0] >= min_div);

    leap     = is_leap(year_q);
    ylen     = leap ? 9'd366 : 9'd365;
    mlen     = month_len(month_q, leap && (month_q == MonthFeb));

    sts_o.year_done  = (days_q < {7'd0, ylen});
    sts_o.month_done = (days_q < {11'd0, mlen}) || (month_q == MonthDec);

    wd_sum   = {1'b0, wd_q} + {1'b0, EpochWday};
    wd_final = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 5'd3;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q     <= t_init;
      days_q  <= '0;
      wd_q    <= '0;
      hour_q  <= '0;
      min_q   <= '0;
      year_q  <= EpochYear;
      month_q <= '0;
    end
    if (cmd_i.day_step) begin
      if (day_ge) t_q <= t_q - day_div;
      days_q <= {days_q[14:0], day_ge};
      wd_q   <= wd_next;
    end
    if (cmd_i.hour_step) begin
      if (hour_ge) t_q <= {15'd0, t_q[16:0] - hour_div};
      hour_q <= {hour_q[3:0], hour_ge};
    end
    if (cmd_i.min_step) begin
      if (min_ge) t_q <= {20'd0, t_q[11:0] - min_div};
      min_q <= {min_q[4:0], min_ge};
    end
    if (cmd_i.year_step) begin
      days_q <= days_q - {7'd0, ylen};
      year_q <= year_q + 8'd1;
    end
    if (cmd_i.month_step) begin
      days_q  <= days_q - {11'd0, mlen};
      month_q <= month_q + 4'd1;
    end
    if (cmd_i.publish) begin
      out_year_q  <= year_q;
      out_month_q <= month_q;
      out_day_q   <= days_q[4:0] + 5'd1;
      out_hour_q  <= hour_q;
      out_min_q   <= min_q;
      out_sec_q   <= t_q[5:0];
      out_wday_q  <= wd_final;
    end
  end

  assign years_since_1900_o = out_year_q;
  assign month_index_o      = out_month_q;
  assign day_of_month_o     = out_day_q;
  assign hour_of_day_o      = out_hour_q;
  assign minute_of_hour_o   = out_min_q;
  assign second_of_minute_o = out_sec_q;
  assign day_of_week_o      = out_wday_q;

endmodule

[hw/rtl/esc_ctrl.sv]
// Controller: sequences load, divider steps, year and month walk, and the output transfer.
`timescale 1ns / 1ps

module esc_ctrl import esc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  esc_sts_t sts_i,
  output esc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    DAYS,
    HOURS,
    MINUTES,
    YEARS,
    MONTHS
  } state_e;

  state_e     state_q;
  logic [3:0] cnt_q;
  logic       out_valid_q;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.step       = cnt_q;
    cmd_o.load       = (state_q == IDLE) && in_valid_i;
    cmd_o.day_step   = (state_q == DAYS);
    cmd_o.hour_step  = (state_q == HOURS);
    cmd_o.min_step   = (state_q == MINUTES);
    cmd_o.year_step  = (state_q == YEARS) && !sts_i.year_done;
    cmd_o.month_step = (state_q == MONTHS) && !sts_i.month_done;
    cmd_o.publish    = (state_q == MONTHS) && sts_i.month_done && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            state_q <= DAYS;
            cnt_q   <= DayBits;
          end
        end
        DAYS: begin
          if (cnt_q == 4'd0) begin
            state_q <= HOURS;
            cnt_q   <= HourBits;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        HOURS: begin
          if (cnt_q == 4'd0) begin
            state_q <= MINUTES;
            cnt_q   <= MinBits;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        MINUTES: begin
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == 4'd0) begin
            state_q <= YEARS;
          end
        end
        YEARS: begin
          if (sts_i.year_done) state_q <= MONTHS;
        end
        MONTHS: begin
          if (cmd_o.publish) state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_publish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending transfer");

  a_publish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> out_valid_o)
    else $error("published result not offered");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == DAYS) && (cnt_q == DayBits))
    else $error("accepted item did not start the day division");

  a_steps_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.day_step, cmd_o.hour_step, cmd_o.min_step,
              cmd_o.year_step, cmd_o.month_step, cmd_o.publish}))
    else $error("more than one datapath command at once");
`endif

endmodule

[hw/rtl/epoch_seconds_to_calendar.sv]
// Top level: Unix timestamp to broken-down local calendar time.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid_i, in_ready_o, unix_seconds_i | to block
//   out     | out_valid_o, out_ready_i, 7 fields     | from block
//   cfg     | cfg_we_i, cfg_wdata_i                  | to block
//
// One item at a time: a load, the day, hour and minute divisions, then the walk over
// whole years past 1970 (one year per cycle) and whole months, then the output transfer.
// Reset clears the controller and sets the UTC offset to 3 hours.
// The result register lets a new transfer in while the previous result waits;
// the next result is held back until that one is taken.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] unix_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  years_since_1900_o,
  output logic [3:0]  month_index_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o,
  output logic [2:0]  day_of_week_o
);

  esc_cmd_t cmd;
  esc_sts_t sts;

  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  esc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .unix_seconds_i     (unix_seconds_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .years_since_1900_o (years_since_1900_o),
    .month_index_o      (month_index_o),
    .day_of_month_o     (day_of_month_o),
    .hour_of_day_o      (hour_of_day_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .second_of_minute_o (second_of_minute_o),
    .day_of_week_o      (day_of_week_o)
  );

endmodule

[dv/epoch_seconds_to_calendar_tb.sv]
// Self-checking testbench for epoch_seconds_to_calendar: timestamps, UTC offsets, saturation.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SecPerDay  = 86400;
  localparam longint      MaxSeconds = 64'd4294967295;

  typedef struct packed {
    logic [7:0] yr;
    logic [3:0] mon;
    logic [4:0] mday;
    logic [4:0] hr;
    logic [5:0] mins;
    logic [5:0] secs;
    logic [2:0] wday;
  } cal_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] unix_seconds_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  years_since_1900_o;
  logic [3:0]  month_index_o;
  logic [4:0]  day_of_month_o;
  logic [4:0]  hour_of_day_o;
  logic [5:0]  minute_of_hour_o;
  logic [5:0]  second_of_minute_o;
  logic [2:0]  day_of_week_o;

  cal_t               expected_dates[$];
  logic signed [4:0]  tz_hours;
  bit                 idling;
  int unsigned        next_gap;
  int unsigned        rx_hold;
  int unsigned        cycles;
  int unsigned        mismatches;
  int unsigned        stamps_sent;
  int unsigned        dates_seen;
  int unsigned        offsets_used;

  epoch_seconds_to_calendar dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .unix_seconds_i     (unix_seconds_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .years_since_1900_o (years_since_1900_o),
    .month_index_o      (month_index_o),
    .day_of_month_o     (day_of_month_o),
    .hour_of_day_o      (hour_of_day_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .second_of_minute_o (second_of_minute_o),
    .day_of_week_o      (day_of_week_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d dates outstanding", cycles,
               expected_dates.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit gregorian_leap(input int unsigned year);
    return (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned mon, input int unsigned year);
    case (mon)
      1:          return gregorian_leap(year) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  // broken-down local time of one timestamp under a given hour offset
  function automatic cal_t calendar_of(input logic [31:0] stamp, input logic signed [4:0] hrs);
    longint      shifted;
    int unsigned t;
    int unsigned days;
    int unsigned rem;
    int unsigned year;
    int unsigned mon;
    cal_t        c;
    shifted = longint'(stamp) + longint'(hrs) * 3600;
    if (shifted < 0) shifted = 0;
    if (shifted > MaxSeconds) shifted = MaxSeconds;
    t    = shifted[31:0];
    days = t / SecPerDay;
    rem  = t % SecPerDay;
    c.wday = 3'((days + 4) % 7);
    year = 1970;
    while (days >= (gregorian_leap(year) ? 366 : 365)) begin
      days -= gregorian_leap(year) ? 366 : 365;
      year++;
    end
    mon = 0;
    while (mon < 11 && days >= days_in_month(mon, year)) begin
      days -= days_in_month(mon, year);
      mon++;
    end
    c.yr   = 8'(year - 1900);
    c.mon  = 4'(mon);
    c.mday = 5'(days + 1);
    c.hr   = 5'(rem / 3600);
    c.mins = 6'((rem % 3600) / 60);
    c.secs = 6'(rem % 60);
    return c;
  endfunction

  // mix of uniform stamps and stamps close to day edges, day edges within a random year, and range edges
  function automatic logic [31:0] pick_stamp();
    longint      s;
    int unsigned year;
    case ($urandom_range(0, 5))
      0, 1: s = longint'($urandom);
      2: s = longint'($urandom_range(0, 49710)) * SecPerDay + $urandom_range(0, 6) - 3;
      3: begin
        s = 0;
        year = $urandom_range(1970, 2105);
        for (int unsigned y = 1970; y < year; y++) s += (gregorian_leap(y) ? 366 : 365) * 86400;
        s += longint'($urandom_range(0, 365)) * SecPerDay + $urandom_range(0, 20) - 10;
      end
      4: s = $urandom_range(0, 100000);
      default: s = MaxSeconds - $urandom_range(0, 100000);
    endcase
    if (s < 0) s = 0;
    if (s > MaxSeconds) s = MaxSeconds;
    return s[31:0];
  endfunction

  always @(posedge clk_i) begin : date_check
    cal_t        got;
    cal_t        want;
    int unsigned stall;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{years_since_1900_o, month_index_o, day_of_month_o, hour_of_day_o,
                minute_of_hour_o, second_of_minute_o, day_of_week_o};
        dates_seen++;
        if (expected_dates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected date %p", $realtime, got);
        end else begin
          want = expected_dates.pop_front();
          if (got.yr !== want.yr || got.mon !== want.mon || got.mday !== want.mday ||
              got.hr !== want.hr || got.mins !== want.mins || got.secs !== want.secs ||
              got.wday !== want.wday) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] date mismatch: expected %p, got %p", $realtime, want, got);
          end
        end
        stall = idling ? $urandom_range(0, 9) : 0;
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          rx_hold     <= stall;
        end
      end else if (!out_ready_i) begin
        if (rx_hold > 1) rx_hold <= rx_hold - 1;
        else out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_stamp(input logic [31:0] stamp);
    repeat (next_gap) @(posedge clk_i);
    in_valid_i     <= 1'b1;
    unix_seconds_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    expected_dates.push_back(calendar_of(stamp, tz_hours));
    stamps_sent++;
    next_gap = idling ? $urandom_range(0, 9) : 0;
    if (next_gap > 0) in_valid_i <= 1'b0;
  endtask

  // called in the step of the last transfer, so valid drops right away
  task automatic stop_sending();
    if (next_gap == 0) begin
      in_valid_i <= 1'b0;
      next_gap = 1;
    end
  endtask

  task automatic set_offset(input logic signed [4:0] hrs);
    stop_sending();
    @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hrs;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tz_hours = hrs;
    offsets_used++;
  endtask

  // reset offset of +3: range ends, leap days, century rule, saturation edge at the top
  task automatic test_reset_offset_edges();
    send_stamp(32'd0);
    send_stamp(32'hFFFF_FFFF);
    send_stamp(32'd68169600);
    send_stamp(32'd946684799);
    send_stamp(32'd951782400);
    send_stamp(32'd4107455999);
    send_stamp(32'd4107542400);
    send_stamp(32'd4294956495);
    send_stamp(32'd4294956496);
  endtask

  task automatic test_saturation();
    set_offset(-5'sd12);
    send_stamp(32'd0);
    send_stamp(32'd43199);
    send_stamp(32'd43200);
    send_stamp(32'd43201);
    send_stamp(32'hFFFF_FFFF);
    set_offset(5'sd14);
    send_stamp(32'd4294916895);
    send_stamp(32'd4294916896);
    send_stamp(32'd0);
    set_offset(-5'sd16);
    send_stamp(32'd57599);
    send_stamp(32'd57600);
    send_stamp(32'hAAAA_AAAA);
    set_offset(5'sd15);
    send_stamp(32'h5555_5555);
    send_stamp(32'd4294913295);
    send_stamp(32'd4294913296);
  endtask

  task automatic test_random_stamps();
    logic signed [4:0] plan[6];
    plan = '{5'sd0, 5'sd14, -5'sd12, 5'($urandom), 5'($urandom), 5'sd3};
    foreach (plan[p]) begin
      set_offset(plan[p]);
      for (int i = 0; i < 100; i++) begin
        if (i % 25 == 0) idling = ($urandom_range(0, 3) != 0);
        send_stamp(pick_stamp());
      end
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    unix_seconds_i <= '0;
    out_ready_i    <= 1'b0;
    tz_hours     = 5'sd3;
    idling       = 1'b1;
    next_gap     = 1;
    rx_hold      = 0;
    cycles       = 0;
    mismatches   = 0;
    stamps_sent  = 0;
    dates_seen   = 0;
    offsets_used = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_offset_edges();
    test_saturation();
    test_random_stamps();

    stop_sending();
    @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("converted %0d timestamps over %0d offset writes plus the reset offset",
             stamps_sent, offsets_used);
    $display("checked %0d dates, %0d failures", dates_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/esc_pkg.sv
hw/rtl/esc_dp.sv
hw/rtl/esc_ctrl.sv
hw/rtl/epoch_seconds_to_calendar.sv
dv/epoch_seconds_to_calendar_tb.sv
